>>> hw/rtl/aecf_pkg.sv
// shared types and constants of the audio echo comb filter
package aecf_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int DELAY_W       = 17;
  localparam int COEF_W        = 16;
  localparam int FRAC_W        = 15;
  localparam int ACC_W         = 34;
  localparam int OPB_W         = COEF_W + 1;
  localparam int PROD_W        = ACC_W + OPB_W;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = DELAY_W;
  localparam int MAX_DELAY_DEF = 65536;

  localparam logic               MODE_RST  = 1'b0;
  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(44100);
  localparam logic [COEF_W-1:0]  GAIN_RST  = COEF_W'(26214);
  localparam logic [COEF_W-1:0]  NORM_RST  = COEF_W'(18204);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO_MODE = 2'd0,
    CFG_DELAY     = 2'd1,
    CFG_GAIN      = 2'd2,
    CFG_NORM      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_MUL_NORM,
    ST_FIN
  } state_t;

  typedef enum logic {
    OP_GAIN_PAST,
    OP_ACC_NORM
  } mul_op_t;

  typedef struct packed {
    logic    en;
    mul_op_t op;
  } mul_ctrl_t;

endpackage

>>> hw/rtl/aecf_in_if.sv
// input sample channel
interface aecf_in_if import aecf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

>>> hw/rtl/aecf_out_if.sv
// result sample channel
interface aecf_out_if import aecf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] echo_sample;

  modport source (output valid, output echo_sample, input ready);
  modport sink (input valid, input echo_sample, output ready);
endinterface

>>> hw/rtl/aecf_ram.sv
// generic single-port-write ram with registered read
module aecf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/aecf_mul.sv
// shared signed multiplier with operand select and registered product
module aecf_mul import aecf_pkg::*; (
  input  logic                     clk,
  input  mul_ctrl_t                ctrl,
  input  logic signed [SAMPLE_W-1:0] past,
  input  logic [COEF_W-1:0]        gain,
  input  logic signed [ACC_W-1:0]  acc,
  input  logic [COEF_W-1:0]        norm,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [ACC_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  always_comb begin
    case (ctrl.op)
      OP_GAIN_PAST: begin
        opa = ACC_W'(past);
        opb = $signed({1'b0, gain});
      end
      default: begin
        opa = acc;
        opb = $signed({1'b0, norm});
      end
    endcase
    prod_nxt = PROD_W'(opa) * PROD_W'(opb);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

>>> hw/rtl/audio_echo_comb_filter.sv
// echo comb filter top level: config registers, sequencer, delay line, output register
//
//   channel   dir  handshake               payload
//   in_ch     in   valid/ready             sample_in  s16
//   out_ch    out  valid/ready             echo_sample s16
//   cfg_*     in   cfg_we, no wait         cfg_index 2b, cfg_wdata 17b
//
// an item goes in order through accept with delay line read, gain multiply, norm multiply, finish
// the shared multiplier is used twice per item; a new item is accepted only after the last one finishes
// rst_n is synchronous and clears control and config; the delay line is not cleared
// a result waits in the output register; a further item waits in finish until it is taken
module audio_echo_comb_filter import aecf_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  aecf_in_if.sink               in_ch,
  aecf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int SW = $clog2(MAX_DELAY + 1);
  localparam int DW = (SW > DELAY_W) ? SW : DELAY_W;

  logic               mode_r;
  logic [DELAY_W-1:0] delay_r;
  logic [COEF_W-1:0]  gain_r;
  logic [COEF_W-1:0]  norm_r;

  state_t state_r, state_nxt;
  logic [AW-1:0]                wp_r;
  logic [SW-1:0]                seen_r;
  logic signed [SAMPLE_W-1:0]   x_r;
  logic                         echo_r;
  logic                         out_valid_r;
  logic signed [SAMPLE_W-1:0]   out_sample_r;

  logic                         in_go;
  logic                         fin_go;
  logic [DW-1:0]                d_ext;
  logic [DW-1:0]                d_eff;
  logic [DW:0]                  diff;
  logic [AW-1:0]                rd_addr;
  logic [SAMPLE_W-1:0]          past;
  mul_ctrl_t                    mul_ctrl;
  logic signed [ACC_W-1:0]      acc;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PROD_W-1:0]     prod_biased;
  logic signed [PROD_W-2*FRAC_W-1:0] quot;
  logic signed [SAMPLE_W-1:0]   y_echo;
  logic signed [SAMPLE_W-1:0]   y;
  logic                         ram_we;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RST;
      delay_r <= DELAY_RST;
      gain_r  <= GAIN_RST;
      norm_r  <= NORM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ECHO_MODE: mode_r  <= cfg_wdata[0];
        CFG_DELAY:     delay_r <= cfg_wdata[DELAY_W-1:0];
        CFG_GAIN:      gain_r  <= cfg_wdata[COEF_W-1:0];
        CFG_NORM:      norm_r  <= cfg_wdata[COEF_W-1:0];
        default:       ;
      endcase
    end
  end

  // effective delay and read address
  always_comb begin
    d_ext = DW'(delay_r);
    if (d_ext == '0) begin
      d_eff = DW'(1);
    end else if (d_ext > DW'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end else begin
      d_eff = d_ext;
    end
    diff = (DW + 1)'(wp_r) - (DW + 1)'(d_eff);
    if (diff[DW]) begin
      rd_addr = AW'(diff + (DW + 1)'(MAX_DELAY));
    end else begin
      rd_addr = AW'(diff);
    end
  end

  assign in_go  = in_ch.valid && in_ch.ready;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mul_ctrl.en = 1'b0;
    mul_ctrl.op = OP_GAIN_PAST;
    ram_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          state_nxt = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        mul_ctrl.en = 1'b1;
        mul_ctrl.op = OP_GAIN_PAST;
        state_nxt   = ST_MUL_NORM;
      end
      ST_MUL_NORM: begin
        mul_ctrl.en = 1'b1;
        mul_ctrl.op = OP_ACC_NORM;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // item and pointer registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      x_r    <= in_ch.sample_in;
      echo_r <= (DW'(seen_r) >= d_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      seen_r <= '0;
    end else if (fin_go) begin
      wp_r <= (wp_r == AW'(MAX_DELAY - 1)) ? '0 : wp_r + AW'(1);
      if (seen_r < SW'(MAX_DELAY)) begin
        seen_r <= seen_r + SW'(1);
      end
    end
  end

  aecf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (mode_r ? y : x_r),
    .re    (in_go),
    .raddr (rd_addr),
    .rdata (past)
  );

  assign acc = $signed({{(ACC_W - SAMPLE_W - FRAC_W){x_r[SAMPLE_W-1]}}, x_r, FRAC_W'(0)})
             + ACC_W'(prod);

  aecf_mul u_mul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .past ($signed(past)),
    .gain (gain_r),
    .acc  (acc),
    .norm (norm_r),
    .prod (prod)
  );

  // truncate toward zero, then saturate
  always_comb begin
    if (prod[PROD_W-1]) begin
      prod_biased = prod + PROD_W'((64'd1 << (2 * FRAC_W)) - 64'd1);
    end else begin
      prod_biased = prod;
    end
    quot = prod_biased[PROD_W-1:2*FRAC_W];
    if (quot > $signed((PROD_W - 2 * FRAC_W)'(32767))) begin
      y_echo = SAMPLE_W'(32767);
    end else if (quot < -$signed((PROD_W - 2 * FRAC_W)'(32768))) begin
      y_echo = $signed(SAMPLE_W'(32768));
    end else begin
      y_echo = quot[SAMPLE_W-1:0];
    end
    y = echo_r ? y_echo : x_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_sample_r <= y;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.echo_sample = out_sample_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> state_r == ST_MUL_GAIN)
    else $error("accepted item did not start the gain multiply");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result appeared without a finish step");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SW'(MAX_DELAY))
    else $error("sample count beyond delay line depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    DW'(wp_r) < DW'(MAX_DELAY))
    else $error("write pointer beyond delay line depth");

  a_fin_advances: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> state_r == ST_IDLE && seen_r != '0)
    else $error("finish did not return to idle with a counted sample");

endmodule

>>> sim/tb_audio_echo_comb_filter.sv
// self-checking testbench of the audio echo comb filter: random stalls, live prediction of every sample
module tb_audio_echo_comb_filter import aecf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_D = MAX_DELAY_DEF;
  localparam int PTR_W = $clog2(MAX_DELAY_DEF);
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ECHO_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                       drv_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] drv_sample = '0;
  logic                       drv_ready = 1'b0;

  aecf_in_if  in_ch ();
  aecf_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.sample_in = drv_sample;
  assign out_ch.ready    = drv_ready;

  audio_echo_comb_filter #(.MAX_DELAY(MAX_D)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // shadow of the config registers
  logic               mode_r  = MODE_RST;
  logic [DELAY_W-1:0] delay_r = DELAY_RST;
  logic [COEF_W-1:0]  gain_r  = GAIN_RST;
  logic [COEF_W-1:0]  norm_r  = NORM_RST;

  // echo memory of the predictor
  logic [SAMPLE_W-1:0] echo_line [MAX_D];
  logic [PTR_W-1:0]    echo_wr = '0;
  int unsigned         echo_seen = 0;

  logic signed [SAMPLE_W-1:0] sample_feed [$];
  logic signed [SAMPLE_W-1:0] sample_due [$];
  int unsigned                bad_count = 0;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  function automatic logic signed [SAMPLE_W-1:0] echo_predict(logic signed [SAMPLE_W-1:0] x);
    int unsigned                d;
    logic [PTR_W-1:0]           rd;
    longint                     acc;
    longint                     prod;
    longint                     q;
    logic signed [SAMPLE_W-1:0] y;
    d = 32'(delay_r);
    if (d == 0) d = 1;
    if (d > MAX_D) d = MAX_D;
    if (echo_seen >= d) begin
      rd   = echo_wr - PTR_W'(d);
      acc  = longint'(x) * 32768 + longint'(gain_r) * longint'($signed(echo_line[rd]));
      prod = acc * longint'(norm_r);
      q    = prod / 64'sd1073741824;
      if (q > 32767) y = S_MAX;
      else if (q < -32768) y = S_MIN;
      else y = q[SAMPLE_W-1:0];
    end else begin
      y = x;
    end
    echo_line[echo_wr] = mode_r ? y : x;
    echo_wr = echo_wr + 1'b1;
    if (echo_seen < MAX_D) echo_seen++;
    return y;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(15))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) sample_due.push_back(echo_predict(drv_sample));
      if (!drv_valid || in_ch.ready) begin
        if (sample_feed.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          drv_valid  <= 1'b1;
          drv_sample <= sample_feed.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && drv_ready) begin
        if (sample_due.size() == 0) begin
          $display("%0t: result expected none, got %0d", $time, out_ch.echo_sample);
          bad_count++;
        end else if (out_ch.echo_sample !== sample_due[0]) begin
          $display("%0t: result expected %0d, got %0d", $time, sample_due[0],
                   out_ch.echo_sample);
          bad_count++;
          void'(sample_due.pop_front());
        end else begin
          void'(sample_due.pop_front());
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        drv_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        drv_ready <= 1'b0;
      end else begin
        drv_ready <= calm || $urandom_range(99) >= 9;
      end
    end
  end

  task automatic wait_drain();
    @(negedge clk);
    while (sample_feed.size() != 0 || drv_valid || sample_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ECHO_MODE: mode_r  = val[0];
      CFG_DELAY:     delay_r = val[DELAY_W-1:0];
      CFG_GAIN:      gain_r  = val[COEF_W-1:0];
      CFG_NORM:      norm_r  = val[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic m, logic [CFG_DATA_W-1:0] d, logic [COEF_W-1:0] g,
                         logic [COEF_W-1:0] n);
    wait_drain();
    write_reg(CFG_ECHO_MODE, CFG_DATA_W'(m));
    write_reg(CFG_DELAY, d);
    write_reg(CFG_GAIN, CFG_DATA_W'(g));
    write_reg(CFG_NORM, CFG_DATA_W'(n));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic feed_random(int n);
    repeat (n) sample_feed.push_back(rand_sample());
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dly;
    logic [COEF_W-1:0]     gn;
    logic [COEF_W-1:0]     nm;
    logic                  md;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, passthrough at the extremes
    sample_feed = '{S_MAX, S_MIN, 16'sd0, -16'sd1};

    // short delay: passthrough, then half of the sum of input and past input
    set_cfg(1'b0, 17'd6, 16'd32768, 16'd16384);
    sample_feed = '{16'sd1, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, -16'sd1, 16'sd0};

    // zero delay acts as one, out-of-range coefficients, feedback saturates
    set_cfg(1'b1, 17'd0, 16'hffff, 16'hffff);
    sample_feed = '{S_MAX, S_MAX, S_MIN, S_MIN, 16'sd5, -16'sd5};

    // back to past inputs with a line holding past outputs, zero gain
    set_cfg(1'b0, 17'd1, 16'd0, 16'd32768);
    sample_feed = '{S_MIN, 16'sd12345, S_MAX};

    // delay beyond the line length acts as the line length
    set_cfg(1'b1, 17'h1ffff, 16'd16384, 16'd21845);
    feed_random(200);

    for (int ph = 0; ph < 10; ph++) begin
      md = 1'($urandom_range(1));
      case ($urandom_range(7))
        0: dly = 17'd1;
        1: dly = 17'd2;
        2: dly = CFG_DATA_W'($urandom_range(3, 64));
        3: dly = CFG_DATA_W'($urandom_range(65, 4000));
        4: dly = 17'd65536;
        5: dly = 17'd0;
        6: dly = CFG_DATA_W'($urandom_range(65537, 131071));
        default: dly = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(5))
        0: gn = 16'd0;
        1: gn = 16'd32768;
        4: gn = COEF_W'($urandom);
        5: gn = GAIN_RST;
        default: gn = COEF_W'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(4))
        0: nm = 16'd16384;
        1: nm = 16'd32768;
        2: nm = COEF_W'(32'h4000_0000 / (32'd32768 + 32'(gn)));
        3: nm = COEF_W'($urandom_range(16384, 32768));
        default: nm = COEF_W'($urandom);
      endcase
      if (ph == 0) begin
        md  = 1'b1;
        dly = 17'd1;
        gn  = 16'd32768;
        nm  = 16'd32768;
      end else if (ph == 1) begin
        md  = 1'b0;
        dly = 17'd65536;
        gn  = 16'd0;
        nm  = 16'd16384;
      end
      set_cfg(md, dly, gn, nm);
      calm = (ph == 5);
      feed_random(200);
      if (ph == 3) hold_req = 1'b1;
    end

    wait_drain();
    calm = 1'b0;
    repeat (20) @(posedge clk);
    if (bad_count == 0 && sample_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
